/* rtl/core/segment_text_scroll_flash_macros.svh */
// assertion macros shared by the segment text engine files
`ifndef SEGMENT_TEXT_SCROLL_FLASH_MACROS_SVH
`define SEGMENT_TEXT_SCROLL_FLASH_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition and consequence in the same cycle
`define STSF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// consequence in the cycle after the condition
`define STSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STSF_ASSERT_NOW(label, ante, cons, msg)
`define STSF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/core/stsf_pkg.sv */
// shared types, constants and glyph table of the segment text engine
package stsf_pkg;

    // default sizes
    localparam int TEXT_MAX_DEF = 32;
    localparam int DIGITS_DEF   = 6;

    // fixed field widths
    localparam int DIGIT_W  = 3;
    localparam int POS_W    = 9;
    localparam int CFG_IDX_W = 3;

    // item kinds carried in tuser
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_COLON = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK   = 3'd3;

    // character codes
    localparam logic [7:0] BLANK_CODE    = 8'hFF;
    localparam logic [7:0] CHAR_FIRST    = 8'h2A;
    localparam logic [7:0] CHAR_LAST     = 8'h5F;
    localparam logic [7:0] CHAR_LC_FIRST = 8'h61;
    localparam logic [7:0] CHAR_LC_LAST  = 8'h7A;
    localparam logic [7:0] CASE_BIT      = 8'h20;
    localparam logic [7:0] NUL_CODE      = 8'h00;

    localparam logic [7:0] GLYPH_COUNT = 8'd54;

    localparam logic [15:0] GLYPH_SEGS [54] = '{
        16'hEAA8, 16'h2A80, 16'h4000, 16'h0A00, 16'h0A51, 16'h4008, 16'h5559, 16'h0118,
        16'h1E11, 16'h1B11, 16'h0B50, 16'h1B41, 16'h1F41, 16'h0111, 16'h1F51, 16'h1B51,
        16'h0000, 16'h0000, 16'h8008, 16'h1A00, 16'h4020, 16'h0000, 16'h0000, 16'h0F51,
        16'h3991, 16'h1441, 16'h3191, 16'h1E41, 16'h0E41, 16'h1D41, 16'h0F50, 16'h2080,
        16'h1510, 16'h8648, 16'h1440, 16'h0578, 16'h8570, 16'h1551, 16'h0E51, 16'h9551,
        16'h8E51, 16'h9021, 16'h2081, 16'h1550, 16'h4448, 16'hC550, 16'hC028, 16'h2028,
        16'h5009, 16'h1441, 16'h8020, 16'h1111, 16'h0000, 16'h1000
    };

    // commands from controller to datapath
    typedef struct packed {
        logic               capture;
        logic               load_char;
        logic               set_colon;
        logic               close_step;
        logic               close_end;
        logic               tick_prep;
        logic               digit_out;
        logic [DIGIT_W-1:0] digit;
    } stsf_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       closes;
        logic       out_free;
    } stsf_status_t;

    // segment word of a glyph index, zero where no pattern exists
    function automatic logic [15:0] glyph_segments(input logic [7:0] g);
        if (g < GLYPH_COUNT)
        begin
            return GLYPH_SEGS[g[5:0]];
        end
        return 16'h0000;
    endfunction

endpackage

/* rtl/core/stsf_ctrl.sv */
// controller state machine sequencing loads, string close and digit output
module stsf_ctrl #(
    parameter int DIGITS = stsf_pkg::DIGITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  stsf_pkg::stsf_status_t status,
    output stsf_pkg::stsf_cmd_t    cmd
);
    import stsf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CLOSE,
        S_OUT
    } state_t;

    localparam logic [DIGIT_W-1:0] LAST_DIGIT = DIGIT_W'(DIGITS - 1);

    state_t             state_reg, state_next;
    logic [DIGIT_W-1:0] count_reg, count_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        cmd.digit  = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (status.mode)
                    MODE_LOAD:
                    begin
                        cmd.load_char = 1'b1;
                        count_next    = '0;
                        state_next    = status.closes ? S_CLOSE : S_IDLE;
                    end
                    MODE_TICK:
                    begin
                        cmd.tick_prep = 1'b1;
                        count_next    = '0;
                        state_next    = S_OUT;
                    end
                    MODE_COLON:
                    begin
                        cmd.set_colon = 1'b1;
                        state_next    = S_IDLE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_CLOSE:
            begin
                cmd.close_step = 1'b1;
                if (count_reg == LAST_DIGIT)
                begin
                    cmd.close_end = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.digit_out = 1'b1;
                    if (count_reg == LAST_DIGIT)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

/* rtl/core/stsf_dp.sv */
// datapath: text store, scroll and flash state, digit glyph selection, output register
module stsf_dp #(
    parameter int TEXT_MAX = stsf_pkg::TEXT_MAX_DEF,
    parameter int DIGITS   = stsf_pkg::DIGITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  stsf_pkg::stsf_cmd_t                cmd,
    output stsf_pkg::stsf_status_t             status,
    input  logic [15:0]                        s_tdata,
    input  logic                               s_tlast,
    input  logic [1:0]                         s_tuser,
    input  logic                               cfg_valid,
    input  logic [stsf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                         cfg_data,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [23:0]                        m_tdata,
    output logic                               m_tlast
);
    import stsf_pkg::*;

    localparam int STORE_DEPTH = TEXT_MAX + DIGITS + 1;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int DIG_W       = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [DIGIT_W-1:0] LAST_DIGIT = DIGIT_W'(DIGITS - 1);
    localparam logic [IDX_W-1:0]   TEXT_LIMIT = IDX_W'(TEXT_MAX);
    localparam logic [POS_W-1:0]   SCROLL_MIN = POS_W'(2 * DIGITS - 1);
    localparam logic [POS_W-1:0]   DIGITS_POS = POS_W'(DIGITS);
    localparam logic [POS_W-1:0]   DEPTH_POS  = POS_W'(STORE_DEPTH);

    // captured item
    logic [1:0] mode_reg;
    logic [7:0] code_reg;
    logic       last_reg;
    logic       colon_in_reg;

    // configuration
    logic [7:0] period_reg, delay_reg, seed_reg;
    logic [5:0] mask_reg;

    // text store and its valid bits
    logic [7:0]             store_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [7:0]             rd_data_reg;
    logic                   rd_blank_reg;

    // engine state
    logic [IDX_W-1:0] load_index_reg, string_end_reg;
    logic [7:0]       ws_reg, win_base_reg;
    logic [7:0]       counter_reg, timer_reg;
    logic             scroll_reg, done_reg, upd_reg, colon_req_reg, colon_shown_reg;
    logic             tick_upd_reg, tick_restore_reg, tick_blank_reg;
    logic [7:0]       shown_reg [DIGITS];

    // output register
    logic                 m_tvalid_reg;
    logic [DIGIT_W-1:0]   out_digit_reg;
    logic [15:0]          out_segs_reg;
    logic                 out_colon_reg, out_scroll_reg, out_done_reg, out_last_reg;

    // character folding and glyph index
    logic [7:0] code_up;
    logic [7:0] glyph_in;
    logic       store_char;

    always_comb
    begin
        code_up = code_reg;
        if (code_reg >= CHAR_LC_FIRST && code_reg <= CHAR_LC_LAST)
        begin
            code_up = code_reg & ~CASE_BIT;
        end
        glyph_in = BLANK_CODE;
        if (code_up >= CHAR_FIRST && code_up <= CHAR_LAST)
        begin
            glyph_in = code_up - CHAR_FIRST;
        end
    end

    assign store_char = cmd.load_char && (code_reg != NUL_CODE) && (load_index_reg < TEXT_LIMIT);

    // store write port
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;

    assign wr_en   = store_char || cmd.close_step;
    assign wr_addr = load_index_reg;
    assign wr_data = cmd.close_step ? BLANK_CODE : glyph_in;

    // update decision taken at the start of a tick
    logic upd_now;
    assign upd_now = upd_reg || (scroll_reg && (counter_reg == 8'd0));

    // store read address: wrapped window position or plain digit position
    logic               rd_en;
    logic [DIGIT_W-1:0] rd_digit;
    logic               rd_upd;
    logic [7:0]         rd_base;
    logic [POS_W-1:0]   rd_sum, rd_end, rd_wrap, rd_pos;
    logic               rd_in_range;
    logic [IDX_W-1:0]   rd_addr;

    always_comb
    begin
        rd_en    = cmd.tick_prep || (cmd.digit_out && (cmd.digit != LAST_DIGIT));
        rd_digit = cmd.tick_prep ? '0 : cmd.digit + 1'b1;
        rd_upd   = cmd.tick_prep ? upd_now : tick_upd_reg;
        rd_base  = cmd.tick_prep ? ws_reg : win_base_reg;
        rd_sum   = POS_W'(rd_base) + POS_W'(rd_digit);
        rd_end   = POS_W'(string_end_reg);
        rd_wrap  = (rd_sum >= rd_end) ? rd_sum - rd_end : rd_sum;
        rd_pos   = rd_upd ? rd_wrap : POS_W'(rd_digit);
        rd_in_range = rd_pos < DEPTH_POS;
        rd_addr  = rd_pos[IDX_W-1:0];
    end

    // memory array with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= store_mem[rd_addr];
            rd_blank_reg <= !rd_in_range || !valid_reg[rd_addr];
        end
    end

    // entries never written read as blank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // capture of an accepted input transfer
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg     <= s_tuser;
            code_reg     <= s_tdata[7:0];
            colon_in_reg <= s_tdata[8];
            last_reg     <= s_tlast;
        end
    end

    // glyph for the digit leaving now
    logic [DIG_W-1:0] dsel;
    logic [7:0]       mask8;
    logic [7:0]       rd_glyph;
    logic [7:0]       glyph_out;
    logic [8:0]       delay_sum;
    logic [7:0]       reload_sum;
    logic [POS_W-1:0] ws_pos;

    always_comb
    begin
        dsel     = cmd.digit[DIG_W-1:0];
        mask8    = 8'(mask_reg);
        rd_glyph = rd_blank_reg ? BLANK_CODE : rd_data_reg;
        priority if (tick_upd_reg)
        begin
            glyph_out = rd_glyph;
        end
        else if (tick_blank_reg && mask8[cmd.digit])
        begin
            glyph_out = BLANK_CODE;
        end
        else if (tick_restore_reg)
        begin
            glyph_out = rd_glyph;
        end
        else
        begin
            glyph_out = shown_reg[dsel];
        end
        delay_sum  = {1'b0, period_reg} + {1'b0, delay_reg};
        reload_sum = delay_sum[8] ? 8'hFF : delay_sum[7:0];
        ws_pos     = POS_W'(ws_reg);
    end

    // configuration, text state, scroll and flash engine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg       <= 8'd20;
            delay_reg        <= 8'd40;
            seed_reg         <= 8'd15;
            mask_reg         <= 6'd0;
            load_index_reg   <= '0;
            string_end_reg   <= '0;
            ws_reg           <= 8'd0;
            win_base_reg     <= 8'd0;
            counter_reg      <= 8'd0;
            timer_reg        <= 8'd0;
            scroll_reg       <= 1'b0;
            done_reg         <= 1'b0;
            upd_reg          <= 1'b0;
            colon_req_reg    <= 1'b0;
            colon_shown_reg  <= 1'b0;
            tick_upd_reg     <= 1'b0;
            tick_restore_reg <= 1'b0;
            tick_blank_reg   <= 1'b0;
            for (int i = 0; i < DIGITS; i++)
            begin
                shown_reg[i] <= BLANK_CODE;
            end
        end
        else
        begin
            // register writes
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_PERIOD: period_reg <= cfg_data;
                    REG_DELAY:  delay_reg  <= cfg_data;
                    REG_SEED:   seed_reg   <= cfg_data;
                    REG_MASK:   mask_reg   <= cfg_data[5:0];
                    default:    ;
                endcase
            end
            // colon request
            if (cmd.set_colon)
            begin
                colon_req_reg <= colon_in_reg;
                upd_reg       <= 1'b1;
            end
            // character store
            if (store_char)
            begin
                load_index_reg <= load_index_reg + 1'b1;
            end
            // trailing blanks and string close
            if (cmd.close_step)
            begin
                if (cmd.close_end)
                begin
                    scroll_reg     <= POS_W'(load_index_reg) > SCROLL_MIN;
                    done_reg       <= 1'b0;
                    string_end_reg <= load_index_reg + 1'b1;
                    load_index_reg <= '0;
                    ws_reg         <= 8'd0;
                    counter_reg    <= reload_sum;
                    upd_reg        <= 1'b1;
                    if (mask_reg != 6'd0)
                    begin
                        timer_reg <= seed_reg;
                    end
                end
                else
                begin
                    load_index_reg <= load_index_reg + 1'b1;
                end
            end
            // frame tick preparation
            if (cmd.tick_prep)
            begin
                if (scroll_reg)
                begin
                    counter_reg <= (counter_reg == 8'd0) ? period_reg : counter_reg - 1'b1;
                end
                tick_restore_reg <= (mask_reg != 6'd0) && (timer_reg == seed_reg);
                tick_blank_reg   <= (mask_reg != 6'd0) && (timer_reg == {1'b0, seed_reg[7:1]});
                if (mask_reg != 6'd0)
                begin
                    timer_reg <= (timer_reg == 8'd0) ? seed_reg : timer_reg - 1'b1;
                end
                tick_upd_reg <= upd_now;
                win_base_reg <= ws_reg;
                upd_reg      <= 1'b0;
                if (upd_now)
                begin
                    if (ws_pos + DIGITS_POS == POS_W'(string_end_reg))
                    begin
                        done_reg <= 1'b1;
                    end
                    ws_reg <= (ws_pos == POS_W'(string_end_reg)) ? 8'd1 : ws_reg + 1'b1;
                    colon_shown_reg <= colon_req_reg;
                end
            end
            // shown glyph follows what leaves
            if (cmd.digit_out)
            begin
                shown_reg[dsel] <= glyph_out;
            end
        end
    end

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.digit_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.digit_out)
        begin
            out_digit_reg  <= cmd.digit;
            out_segs_reg   <= glyph_segments(glyph_out);
            out_colon_reg  <= colon_shown_reg;
            out_scroll_reg <= scroll_reg;
            out_done_reg   <= done_reg;
            out_last_reg   <= (cmd.digit == LAST_DIGIT);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_done_reg, out_scroll_reg, out_colon_reg,
                       out_segs_reg, out_digit_reg};
    assign m_tlast  = out_last_reg;

    assign status.mode     = mode_reg;
    assign status.closes   = (code_reg == NUL_CODE) || last_reg;
    assign status.out_free = !m_tvalid_reg || m_tready;

endmodule

/* rtl/core/segment_text_scroll_flash.sv */
// Text engine for a starburst segment display.
// Input stream: tuser selects the item kind (load character, frame tick, set colon),
// tdata carries the character code and the colon request, tlast marks the final
// character of a string. Load and colon transfers give no result; a null code or
// tlast closes the string, which writes DIGITS trailing blanks one per cycle.
// Each frame tick gives DIGITS result transfers, leftmost digit first, with the
// segment word and the colon, scrolling and scroll-done flags; tlast marks the
// last digit of the tick.
// Sequencing: one item in flight at a time. A character load or a colon item is
// captured, then executed; a close adds DIGITS blank writes. A frame tick reads one
// digit per cycle from the single store read port while the output register is free.
// The output register holds a result while the receiver stalls; the digit
// sequencer waits for it and the next item is taken as soon as the last digit
// of a tick sits in the register.
// Reset restores the register defaults, blanks the text store through per-entry
// valid bits and the shown digits at once; no clearing pass is needed.
// Register writes on the cfg channel are always taken; write them while idle.
`include "segment_text_scroll_flash_macros.svh"
module segment_text_scroll_flash #(
    parameter int TEXT_MAX = stsf_pkg::TEXT_MAX_DEF,
    parameter int DIGITS   = stsf_pkg::DIGITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,  // char_code[7:0], colons_on[8], zero fill
    input  logic                           s_tlast,
    input  logic [1:0]                     s_tuser,  // mode[1:0]
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [stsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,  // digit[2:0], segments[18:3], colon[19],
                                                     // scrolling[20], scroll_done[21], zero fill
    output logic                           m_tlast
);
    import stsf_pkg::*;

    stsf_cmd_t    cmd;
    stsf_status_t status;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // sequencer
    stsf_ctrl #(
        .DIGITS (DIGITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // store and display state
    stsf_dp #(
        .TEXT_MAX (TEXT_MAX),
        .DIGITS   (DIGITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // one item at a time: an accepted transfer blocks the next cycle
    `STSF_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input taken while busy")
    // a stalled result stays put
    `STSF_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    // last flag sits on the rightmost digit
    `STSF_ASSERT_NOW(a_last_digit, m_tvalid && m_tlast, m_tdata[2:0] == 3'(DIGITS - 1), "last flag on wrong digit")
    // input is open only with the final digit of a tick pending
    `STSF_ASSERT_NOW(a_ready_pending, m_tvalid && s_tready, m_tlast, "input open mid tick")

endmodule

/* dv/tb_top.sv */
// self-checking testbench for the segment display text engine
module tb_top;
    import stsf_pkg::*;

    localparam int TEXT_MAX      = TEXT_MAX_DEF;
    localparam int DIGITS        = DIGITS_DEF;
    localparam int STORE_DEPTH   = TEXT_MAX + DIGITS + 1;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_ITEMS   = 55;

    // mode value the block ignores
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // printable ranges used by the character picker
    localparam logic [7:0] UPPER_A  = 8'h41;
    localparam logic [7:0] UPPER_Z  = 8'h5A;
    localparam logic [7:0] DIGIT_HI = 8'h40;
    localparam logic [7:0] BRACKET  = 8'h5B;
    localparam logic [7:0] SPACE    = 8'h20;

    typedef struct {
        logic [2:0]  pos;
        logic [15:0] segs;
        logic        colon;
        logic        scrolling;
        logic        done;
        logic        final_digit;
    } digit_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic [1:0]  s_tuser = MODE_LOAD;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_PERIOD;
    logic [7:0]  cfg_data = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    // expected digit words in output order
    digit_word_t pending_digits[$];
    int          errors = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    bit          tx_steady = 1'b0;

    // mirror of the text engine state
    logic [7:0] period_r, delay_r, seed_r;
    logic [5:0] mask_r;
    logic [7:0] text_mem [STORE_DEPTH];
    logic [7:0] shown [DIGITS];
    int         load_pos, text_end;
    logic [7:0] win_pos, scroll_cnt, flash_cnt;
    bit         scroll_on, scroll_seen, update_due, colon_req, colon_shown;

    segment_text_scroll_flash uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // text engine predictor
    // ---------------------------------------------------------------

    function automatic void reset_engine();
        period_r = 8'd20;
        delay_r  = 8'd40;
        seed_r   = 8'd15;
        mask_r   = '0;
        foreach (text_mem[i]) text_mem[i] = BLANK_CODE;
        foreach (shown[i]) shown[i] = BLANK_CODE;
        load_pos    = 0;
        text_end    = 0;
        win_pos     = '0;
        scroll_cnt  = '0;
        flash_cnt   = '0;
        scroll_on   = 1'b0;
        scroll_seen = 1'b0;
        update_due  = 1'b0;
        colon_req   = 1'b0;
        colon_shown = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        case (idx)
            REG_PERIOD: period_r = val;
            REG_DELAY:  delay_r  = val;
            REG_SEED:   seed_r   = val;
            REG_MASK:   mask_r   = val[5:0];
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] read_text(input int pos);
        return (pos < STORE_DEPTH) ? text_mem[pos] : BLANK_CODE;
    endfunction

    // close: pad with blanks, restart the window, arm scrolling
    function automatic void close_text();
        int sum;
        scroll_on   = (load_pos > DIGITS);
        scroll_seen = 1'b0;
        for (int k = 0; k < DIGITS; k++)
        begin
            if (load_pos < STORE_DEPTH)
                text_mem[load_pos] = BLANK_CODE;
            load_pos++;
        end
        text_end   = load_pos;
        win_pos    = '0;
        sum        = int'(period_r) + int'(delay_r);
        scroll_cnt = (sum > 255) ? 8'd255 : 8'(sum);
        update_due = 1'b1;
        if (mask_r != 0)
            flash_cnt = seed_r;
        load_pos = 0;
    endfunction

    // fold case, map to a glyph index, store unless full
    function automatic void take_char(input logic [7:0] code, input logic fin);
        logic [7:0] c;
        logic [7:0] g;
        c = code;
        if (code != NUL_CODE)
        begin
            g = BLANK_CODE;
            if (c >= CHAR_LC_FIRST && c <= CHAR_LC_LAST)
                c = c & ~CASE_BIT;
            if (c >= CHAR_FIRST && c <= CHAR_LAST)
                g = c - CHAR_FIRST;
            if (load_pos < TEXT_MAX)
            begin
                text_mem[load_pos] = g;
                load_pos++;
            end
        end
        if (code == NUL_CODE || fin)
            close_text();
    endfunction

    // scroll counter, flashing, window update, then one word per digit
    function automatic void run_frame();
        int pos;
        digit_word_t w;
        if (scroll_on)
        begin
            if (scroll_cnt == 0)
            begin
                update_due = 1'b1;
                scroll_cnt = period_r;
            end
            else
                scroll_cnt--;
        end
        if (mask_r != 0)
        begin
            if (flash_cnt == seed_r)
                for (int c = 0; c < DIGITS; c++) shown[c] = text_mem[c];
            if (flash_cnt == (seed_r >> 1))
                for (int c = 0; c < DIGITS; c++)
                    if (mask_r[c]) shown[c] = BLANK_CODE;
            if (flash_cnt == 0)
                flash_cnt = seed_r;
            else
                flash_cnt--;
        end
        if (update_due)
        begin
            for (int c = 0; c < DIGITS; c++)
            begin
                pos = int'(win_pos) + c;
                if (pos >= text_end)
                    pos -= text_end;
                shown[c] = read_text(pos);
            end
            if (int'(win_pos) + DIGITS == text_end)
                scroll_seen = 1'b1;
            if (int'(win_pos) == text_end)
                win_pos = 8'd1;
            else
                win_pos++;
            colon_shown = colon_req;
            update_due  = 1'b0;
        end
        for (int c = 0; c < DIGITS; c++)
        begin
            w.pos         = 3'(c);
            w.segs        = (shown[c] < GLYPH_COUNT) ? GLYPH_SEGS[shown[c]] : 16'h0000;
            w.colon       = colon_shown;
            w.scrolling   = scroll_on;
            w.done        = scroll_seen;
            w.final_digit = (c == DIGITS - 1);
            pending_digits.push_back(w);
        end
    endfunction

    function automatic void predict_item(input logic [1:0] kind, input logic [7:0] code,
                                         input logic fin, input logic colons);
        case (kind)
            MODE_LOAD:  take_char(code, fin);
            MODE_TICK:  run_frame();
            MODE_COLON:
            begin
                colon_req  = colons;
                update_due = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // one input transfer, predicted on acceptance
    task automatic send_item(input logic [1:0] kind, input logic [7:0] code,
                             input logic fin, input logic colons);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'b0, colons, code};
        s_tlast  <= fin;
        do @(posedge clk); while (!s_tready);
        predict_item(kind, code, fin, colons);
        items_sent++;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic send_noise();
        send_item(MODE_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // write all four registers back to back
    task automatic program_regs(input logic [7:0] period, input logic [7:0] delay,
                                input logic [7:0] seed, input logic [7:0] mask_bits);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [7:0] vals [4];
        idx  = '{REG_PERIOD, REG_DELAY, REG_SEED, REG_MASK};
        vals = '{period, delay, seed, mask_bits};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            apply_reg(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // let every expected word arrive, then allow for a close still running
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_digits.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range(UPPER_A, UPPER_Z));
            3, 4:    return 8'($urandom_range(CHAR_LC_FIRST, CHAR_LC_LAST));
            5:       return 8'($urandom_range(CHAR_FIRST, DIGIT_HI));
            6:       return 8'($urandom_range(BRACKET, CHAR_LAST));
            7:       return SPACE;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // a string closed by tlast or by a null, with stray ticks and noise inside
    task automatic send_string(input int len);
        bit by_last;
        by_last = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_tick();
            if ($urandom_range(0, 29) == 0)
                send_noise();
            send_item(MODE_LOAD, pick_char(), by_last && (k == len - 1), 1'($urandom));
        end
        if (!by_last)
            send_item(MODE_LOAD, NUL_CODE, 1'($urandom), 1'($urandom));
    endtask

    // ---------------------------------------------------------------
    // result checker
    // ---------------------------------------------------------------

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : check_digits
        digit_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_digits.size() == 0)
            begin
                $error("result transfer with nothing expected: tdata %h", m_tdata);
                errors++;
            end
            else
            begin
                want = pending_digits.pop_front();
                check_field("digit", want.pos, m_tdata[2:0]);
                check_field("segments", want.segs, m_tdata[18:3]);
                check_field("colon", want.colon, m_tdata[19]);
                check_field("scrolling", want.scrolling, m_tdata[20]);
                check_field("scroll_done", want.done, m_tdata[21]);
                check_field("final_res", want.final_digit, m_tlast);
            end
        end
    end

    // receiver stalls: short runs mostly, sometimes a long open stretch
    initial
    begin : drive_ready
        int hold;
        int idle;
        while (!rst_n) @(posedge clk);
        forever
        begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (hold) @(posedge clk);
            idle = pick_gap();
            if (idle > 0)
            begin
                m_tready <= 1'b0;
                repeat (idle) @(posedge clk);
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // blank display after reset, colon update before any string closed, ignored mode
    task automatic test_blank_start();
        send_tick();
        send_item(MODE_COLON, NUL_CODE, 1'b0, 1'b1);
        send_tick();
        send_noise();
        send_tick();
    endtask

    // character mapping extremes, scrolling text, empty close by null with tlast
    task automatic test_char_map();
        logic [7:0] chars [10];
        chars = '{CHAR_LC_FIRST, CHAR_LC_LAST, CHAR_FIRST, CHAR_LAST, 8'h29,
                  8'h60, 8'h7B, 8'hFF, 8'h01, 8'h6D};
        wait_drained();
        program_regs(8'd0, 8'd2, 8'd4, 8'h21);
        foreach (chars[i])
            send_item(MODE_LOAD, chars[i], i == 9, 1'b0);
        repeat (3) send_tick();
        send_item(MODE_COLON, NUL_CODE, 1'b0, 1'b0);
        send_tick();
        send_item(MODE_LOAD, NUL_CODE, 1'b1, 1'b1);
        send_tick();
    endtask

    // random strings and frame ticks across several register settings
    task automatic test_random_phases();
        int quota;
        int len;
        int r;
        for (int phase = 0; phase < 8; phase++)
        begin
            wait_drained();
            case (phase)
                0: program_regs(8'd0, 8'd0, 8'd1, 8'h3F);
                1: program_regs(8'd255, 8'd255, 8'd255, 8'h00);
                2: program_regs(8'd0, 8'd3, 8'd0, 8'hFF);
                3: program_regs(8'd2, 8'd1, 8'd2, 8'h15);
                4: program_regs(8'd200, 8'd100, 8'd7, 8'hEA);
                default: program_regs(8'($urandom_range(0, 3)), 8'($urandom_range(0, 5)),
                                      8'($urandom_range(1, 20)), 8'($urandom));
            endcase
            tx_steady = (phase % 3 == 2);
            quota = items_sent + PHASE_ITEMS;
            while (items_sent < quota)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    len = $urandom_range(0, 12);
                else if (r < 90)
                    len = $urandom_range(13, 31);
                else
                    len = $urandom_range(32, 40);
                send_string(len);
                repeat ($urandom_range(1, len + 10))
                begin
                    r = $urandom_range(0, 19);
                    if (r < 2)
                        send_item(MODE_COLON, 8'($urandom), 1'($urandom), 1'($urandom));
                    else if (r == 2)
                        send_noise();
                    else
                        send_tick();
                end
            end
            tx_steady = 1'b0;
        end
    endtask

    initial
    begin
        reset_engine();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_blank_start();
        test_char_map();
        test_random_phases();
        wait_drained();
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
